// File: design/space_vector_pwm_generator_core_defines.svh
// assertion macros used by the checker file
// each one samples on clk and stays quiet while rst_n is low
`ifndef SPACE_VECTOR_PWM_GENERATOR_CORE_DEFINES_SVH
`define SPACE_VECTOR_PWM_GENERATOR_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SVPWM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SVPWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/svpwm_pkg.sv
`timescale 1ns / 1ps

package svpwm_pkg;

    // fixed widths of the words
    localparam int ACTION_W       = 4;
    localparam int DUTY_BITS      = 16;
    localparam int INDEX_W        = 15;
    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int SINE_W         = 16;
    localparam int VOLT_W         = 31;
    localparam int SUM_W          = VOLT_W + 1;
    localparam int VAL_W          = VOLT_W + 2;

    // sine quarter table geometry
    localparam int QTR_BITS     = SINE_ADDR_BITS - 2;
    localparam int SINE_TAB_LEN = (1 << QTR_BITS) + 1;

    // duty scaling from Q29 voltage to a fraction of full scale
    localparam int DUTY_SHIFT = 30 - DUTY_BITS;

    typedef logic [DUTY_BITS-1:0]      duty_t;
    typedef logic [INDEX_W-1:0]        index_t;
    typedef logic [PHASE_BITS-1:0]     phase_t;
    typedef logic signed [SINE_W-1:0]  sine_t;
    typedef logic [SINE_W-2:0]         sine_mag_t;
    typedef logic signed [VOLT_W-1:0]  volt_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [VAL_W-1:0]   val_t;
    typedef sine_mag_t sine_tab_t [SINE_TAB_LEN];

    localparam phase_t THIRD_TURN =
        PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);
    localparam val_t HALF_Q29   = VAL_W'(64'sd536870912);
    localparam val_t DUTY_ROUND = VAL_W'(64'sd1 << (DUTY_SHIFT - 1));
    localparam val_t DUTY_TOP   = VAL_W'((64'sd1 << DUTY_BITS) - 64'sd1);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TEST = 2'd1,
        MODE_SV   = 2'd2
    } mode_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 4'd0,
        ACT_STOP       = 4'd1,
        ACT_START_TEST = 4'd2,
        ACT_START_SV   = 4'd3,
        ACT_SET_INDEX  = 4'd4,
        ACT_SET_STEP   = 4'd5,
        ACT_SET_DUTY_U = 4'd6,
        ACT_SET_DUTY_V = 4'd7,
        ACT_SET_DUTY_W = 4'd8
    } action_t;

    // what the result stage does to the duty registers
    typedef enum logic [2:0] {
        DOP_KEEP     = 3'd0,
        DOP_CLEAR    = 3'd1,
        DOP_LOAD_ALL = 3'd2,
        DOP_SET_U    = 3'd3,
        DOP_SET_V    = 3'd4,
        DOP_SET_W    = 3'd5,
        DOP_SV       = 3'd6
    } duty_op_t;

    // control and duty words that ride along the pipeline
    typedef struct packed {
        duty_op_t op;
        mode_t    mode;
        logic     enable;
        duty_t    du;
        duty_t    dv;
        duty_t    dw;
    } svpwm_item_t;

    // quarter wave sine magnitude, Q0.15, from the polynomial in Q14
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        int          i;
        int unsigned x;
        int unsigned x2;
        int unsigned t1;
        int unsigned t2;
        int unsigned s;
        for (i = 0; i < SINE_TAB_LEN; i++)
        begin
            x  = i << (16 - SINE_ADDR_BITS);
            x2 = (x * x) >> 14;
            t1 = 10512 - ((1160 * x2) >> 14);
            t2 = 25736 - ((x2 * t1) >> 14);
            s  = ((x * t2) >> 14) << 1;
            if (s > 32767)
            begin
                s = 32767;
            end
            tab[i] = sine_mag_t'(s);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    // offset voltage to saturated duty, rounded half up
    function automatic duty_t to_duty(volt_t v, volt_t half);
        val_t val;
        val_t d;
        val = VAL_W'(v) - VAL_W'(half) + HALF_Q29;
        d   = (val + DUTY_ROUND) >>> DUTY_SHIFT;
        if (val <= 0)
        begin
            return '0;
        end
        else if (d > DUTY_TOP)
        begin
            return DUTY_TOP[DUTY_BITS-1:0];
        end
        return d[DUTY_BITS-1:0];
    endfunction

endpackage

// File: design/svpwm_in_if.sv
`timescale 1ns / 1ps

interface svpwm_in_if;
    import svpwm_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    duty_t               duty_u;
    duty_t               duty_v;
    duty_t               duty_w;
    index_t              mod_index;
    phase_t              phase_step;

    modport source (
        output valid,
        output action,
        output duty_u,
        output duty_v,
        output duty_w,
        output mod_index,
        output phase_step,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  duty_u,
        input  duty_v,
        input  duty_w,
        input  mod_index,
        input  phase_step,
        output ready
    );
endinterface

// File: design/svpwm_out_if.sv
`timescale 1ns / 1ps

interface svpwm_out_if;
    import svpwm_pkg::*;

    logic       valid;
    logic       ready;
    duty_t      pwm_u;
    duty_t      pwm_v;
    duty_t      pwm_w;
    logic [1:0] drive_mode;
    logic       driver_enable;

    modport source (
        output valid,
        output pwm_u,
        output pwm_v,
        output pwm_w,
        output drive_mode,
        output driver_enable,
        input  ready
    );

    modport sink (
        input  valid,
        input  pwm_u,
        input  pwm_v,
        input  pwm_w,
        input  drive_mode,
        input  driver_enable,
        output ready
    );
endinterface

// File: design/svpwm_sine_lookup.sv
`timescale 1ns / 1ps

module svpwm_sine_lookup (
    input  svpwm_pkg::phase_t phase,
    output svpwm_pkg::sine_t  sine
);
    import svpwm_pkg::*;

    logic [SINE_ADDR_BITS-1:0] addr;
    logic [1:0]                quarter;
    logic [QTR_BITS-1:0]       offs;
    logic [QTR_BITS:0]         idx;
    sine_mag_t                 mag;

    // top phase bits pick the quarter and the place within it
    assign addr    = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign quarter = addr[SINE_ADDR_BITS-1 -: 2];
    assign offs    = addr[QTR_BITS-1:0];

    // odd quarters run the table backward
    always_comb
    begin
        if (quarter[0])
        begin
            idx = (QTR_BITS+1)'(SINE_TAB_LEN - 1) - {1'b0, offs};
        end
        else
        begin
            idx = {1'b0, offs};
        end
    end

    assign mag = SINE_TAB[idx];

    // second half turn is negative
    always_comb
    begin
        if (quarter[1])
        begin
            sine = -$signed({1'b0, mag});
        end
        else
        begin
            sine = $signed({1'b0, mag});
        end
    end
endmodule

// File: design/space_vector_pwm_generator_core.sv
`timescale 1ns / 1ps

// Three-phase PWM duty generator with idle, test and space-vector modes. Each word on req is
// one action (tick, stop, start test, start space vector, set index, set step, set duty u/v/w)
// and yields exactly one word on rsp holding the three duties, the mode and the driver enable
// after that action. A space-vector tick advances the phase accumulator by the step, looks up
// a quarter-wave sine table for three phases 120 degrees apart, scales by the Q1.14 index,
// injects the min-max offset and maps the result to saturated 16-bit duties. One word is taken
// every clock while rsp is not stalled; each word passes through the phase register and the sine
// lookup, index multiply, offset and duty stages. Stages hold their word while rsp is stalled
// and empty stages keep taking new words, so req.ready only falls once all five are full.
module space_vector_pwm_generator_core (
    input logic        clk,
    input logic        rst_n,
    svpwm_in_if.sink   req,
    svpwm_out_if.source rsp
);
    import svpwm_pkg::*;

    // mode and phase state, updated as each word is accepted
    mode_t       mode_reg;
    mode_t       mode_next;
    logic        enable_reg;
    logic        enable_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    phase_t      step_reg;
    phase_t      step_next;
    index_t      index_reg;
    index_t      index_next;
    svpwm_item_t item_next;
    logic        accept;

    // pipeline stages
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        s3_valid_reg;
    logic        s4_valid_reg;
    logic        out_valid_reg;
    logic        load_s1;
    logic        load_s2;
    logic        load_s3;
    logic        load_s4;
    logic        load_out;
    svpwm_item_t s1_item_reg;
    svpwm_item_t s2_item_reg;
    svpwm_item_t s3_item_reg;
    svpwm_item_t s4_item_reg;
    phase_t      s1_phase_reg;
    index_t      s1_index_reg;
    index_t      s2_index_reg;
    phase_t      phase_v;
    phase_t      phase_w;
    sine_t       sine_u;
    sine_t       sine_v;
    sine_t       sine_w;
    sine_t       s2_sine_u_reg;
    sine_t       s2_sine_v_reg;
    sine_t       s2_sine_w_reg;
    volt_t       s3_volt_u_reg;
    volt_t       s3_volt_v_reg;
    volt_t       s3_volt_w_reg;
    volt_t       volt_max;
    volt_t       volt_min;
    sum_t        volt_sum;
    sum_t        volt_sum_adj;
    volt_t       s4_volt_u_reg;
    volt_t       s4_volt_v_reg;
    volt_t       s4_volt_w_reg;
    volt_t       s4_half_reg;

    // result register
    duty_t       pwm_u_reg;
    duty_t       pwm_v_reg;
    duty_t       pwm_w_reg;
    duty_t       pwm_u_next;
    duty_t       pwm_v_next;
    duty_t       pwm_w_next;
    mode_t       out_mode_reg;
    logic        out_enable_reg;

    // stage loads, each stage moves when the next has room
    assign load_out  = !out_valid_reg || rsp.ready;
    assign load_s4   = !s4_valid_reg || load_out;
    assign load_s3   = !s3_valid_reg || load_s4;
    assign load_s2   = !s2_valid_reg || load_s3;
    assign load_s1   = !s1_valid_reg || load_s2;
    assign req.ready = load_s1;
    assign accept    = req.valid && load_s1;

    // action decode
    always_comb
    begin
        mode_next    = mode_reg;
        enable_next  = enable_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        index_next   = index_reg;
        item_next.op = DOP_KEEP;
        unique case (action_t'(req.action))
            ACT_TICK:
            begin
                if (mode_reg == MODE_SV)
                begin
                    phase_next   = phase_reg + step_reg;
                    item_next.op = DOP_SV;
                end
            end
            ACT_STOP:
            begin
                mode_next    = MODE_IDLE;
                enable_next  = 1'b0;
                item_next.op = DOP_CLEAR;
            end
            ACT_START_TEST:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    mode_next    = MODE_TEST;
                    enable_next  = 1'b1;
                    item_next.op = DOP_LOAD_ALL;
                end
            end
            ACT_START_SV:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    mode_next   = MODE_SV;
                    enable_next = 1'b1;
                    index_next  = req.mod_index;
                    step_next   = req.phase_step;
                end
            end
            ACT_SET_INDEX:
            begin
                if (mode_reg == MODE_SV)
                begin
                    index_next = req.mod_index;
                end
            end
            ACT_SET_STEP:
            begin
                if (mode_reg == MODE_SV)
                begin
                    step_next = req.phase_step;
                end
            end
            ACT_SET_DUTY_U:
            begin
                if (mode_reg == MODE_TEST)
                begin
                    item_next.op = DOP_SET_U;
                end
            end
            ACT_SET_DUTY_V:
            begin
                if (mode_reg == MODE_TEST)
                begin
                    item_next.op = DOP_SET_V;
                end
            end
            ACT_SET_DUTY_W:
            begin
                if (mode_reg == MODE_TEST)
                begin
                    item_next.op = DOP_SET_W;
                end
            end
            default:
            begin
            end
        endcase
        item_next.mode   = mode_next;
        item_next.enable = enable_next;
        item_next.du     = req.duty_u;
        item_next.dv     = req.duty_v;
        item_next.dw     = req.duty_w;
    end

    // mode and phase state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            enable_reg <= 1'b0;
            phase_reg  <= '0;
            step_reg   <= '0;
            index_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            enable_reg <= enable_next;
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            index_reg  <= index_next;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s1)
            begin
                s1_valid_reg <= req.valid;
            end
            if (load_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (load_s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (load_s4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // phase of the v and w legs
    assign phase_v = s1_phase_reg + THIRD_TURN;
    assign phase_w = s1_phase_reg - THIRD_TURN;

    svpwm_sine_lookup u_sine_u (
        .phase (s1_phase_reg),
        .sine  (sine_u)
    );

    svpwm_sine_lookup u_sine_v (
        .phase (phase_v),
        .sine  (sine_v)
    );

    svpwm_sine_lookup u_sine_w (
        .phase (phase_w),
        .sine  (sine_w)
    );

    // min and max of the three voltages, half their sum toward zero
    always_comb
    begin
        volt_max = s3_volt_u_reg;
        volt_min = s3_volt_u_reg;
        if (s3_volt_v_reg > volt_max)
        begin
            volt_max = s3_volt_v_reg;
        end
        if (s3_volt_w_reg > volt_max)
        begin
            volt_max = s3_volt_w_reg;
        end
        if (s3_volt_v_reg < volt_min)
        begin
            volt_min = s3_volt_v_reg;
        end
        if (s3_volt_w_reg < volt_min)
        begin
            volt_min = s3_volt_w_reg;
        end
        volt_sum     = SUM_W'(volt_max) + SUM_W'(volt_min);
        volt_sum_adj = volt_sum + $signed({{(SUM_W-1){1'b0}}, volt_sum[SUM_W-1]});
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= item_next;
            s1_phase_reg <= phase_next;
            s1_index_reg <= index_reg;
        end
        if (load_s2 && s1_valid_reg)
        begin
            s2_item_reg   <= s1_item_reg;
            s2_index_reg  <= s1_index_reg;
            s2_sine_u_reg <= sine_u;
            s2_sine_v_reg <= sine_v;
            s2_sine_w_reg <= sine_w;
        end
        if (load_s3 && s2_valid_reg)
        begin
            s3_item_reg   <= s2_item_reg;
            s3_volt_u_reg <= volt_t'($signed({1'b0, s2_index_reg}) * s2_sine_u_reg);
            s3_volt_v_reg <= volt_t'($signed({1'b0, s2_index_reg}) * s2_sine_v_reg);
            s3_volt_w_reg <= volt_t'($signed({1'b0, s2_index_reg}) * s2_sine_w_reg);
        end
        if (load_s4 && s3_valid_reg)
        begin
            s4_item_reg   <= s3_item_reg;
            s4_volt_u_reg <= s3_volt_u_reg;
            s4_volt_v_reg <= s3_volt_v_reg;
            s4_volt_w_reg <= s3_volt_w_reg;
            s4_half_reg   <= volt_t'(volt_sum_adj >>> 1);
        end
    end

    // duty register update in word order
    always_comb
    begin
        pwm_u_next = pwm_u_reg;
        pwm_v_next = pwm_v_reg;
        pwm_w_next = pwm_w_reg;
        unique case (s4_item_reg.op)
            DOP_KEEP:
            begin
            end
            DOP_CLEAR:
            begin
                pwm_u_next = '0;
                pwm_v_next = '0;
                pwm_w_next = '0;
            end
            DOP_LOAD_ALL:
            begin
                pwm_u_next = s4_item_reg.du;
                pwm_v_next = s4_item_reg.dv;
                pwm_w_next = s4_item_reg.dw;
            end
            DOP_SET_U:
            begin
                pwm_u_next = s4_item_reg.du;
            end
            DOP_SET_V:
            begin
                pwm_v_next = s4_item_reg.dv;
            end
            DOP_SET_W:
            begin
                pwm_w_next = s4_item_reg.dw;
            end
            DOP_SV:
            begin
                pwm_u_next = to_duty(s4_volt_u_reg, s4_half_reg);
                pwm_v_next = to_duty(s4_volt_v_reg, s4_half_reg);
                pwm_w_next = to_duty(s4_volt_w_reg, s4_half_reg);
            end
            default:
            begin
            end
        endcase
    end

    // result register, duties persist between words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_u_reg      <= '0;
            pwm_v_reg      <= '0;
            pwm_w_reg      <= '0;
            out_mode_reg   <= MODE_IDLE;
            out_enable_reg <= 1'b0;
        end
        else if (load_out && s4_valid_reg)
        begin
            pwm_u_reg      <= pwm_u_next;
            pwm_v_reg      <= pwm_v_next;
            pwm_w_reg      <= pwm_w_next;
            out_mode_reg   <= s4_item_reg.mode;
            out_enable_reg <= s4_item_reg.enable;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.pwm_u         = pwm_u_reg;
    assign rsp.pwm_v         = pwm_v_reg;
    assign rsp.pwm_w         = pwm_w_reg;
    assign rsp.drive_mode    = out_mode_reg;
    assign rsp.driver_enable = out_enable_reg;
endmodule

// File: design/svpwm_checker.sv
`timescale 1ns / 1ps
`include "space_vector_pwm_generator_core_defines.svh"

module svpwm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input svpwm_pkg::duty_t pwm_u,
    input svpwm_pkg::duty_t pwm_v,
    input svpwm_pkg::duty_t pwm_w,
    input logic [1:0]       drive_mode,
    input logic             driver_enable
);
    import svpwm_pkg::*;

    // driver is on exactly when a mode is running
    `SVPWM_ASSERT_IMPLY(a_enable_follows_mode, rsp_valid, driver_enable == (drive_mode != MODE_IDLE), "driver enable disagrees with mode")

    // idle always reports zero duties
    `SVPWM_ASSERT_IMPLY(a_idle_duties_zero, rsp_valid && drive_mode == MODE_IDLE, pwm_u == '0 && pwm_v == '0 && pwm_w == '0, "nonzero duty in idle mode")

    // stalled result word holds
    `SVPWM_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(pwm_u) && $stable(pwm_v) && $stable(pwm_w) && $stable(drive_mode) && $stable(driver_enable), "result word changed while stalled")
endmodule

bind space_vector_pwm_generator_core svpwm_checker u_svpwm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .pwm_u         (rsp.pwm_u),
    .pwm_v         (rsp.pwm_v),
    .pwm_w         (rsp.pwm_w),
    .drive_mode    (rsp.drive_mode),
    .driver_enable (rsp.driver_enable)
);
